FILE: rtl/enr_pkg.sv
// ----------------------------------------------------------------------------
// Euclidean norm stream package
// Shared transaction types, configuration types and constants.
// ----------------------------------------------------------------------------
package enr_pkg;

  localparam int FIELD_W     = 24;
  localparam int STRIDE_W    = 8;
  localparam int NORM_W      = 32;
  localparam int ACC_W       = 64;
  localparam int REG_IDX_W   = 1;
  localparam int FIFO_DEPTH  = 4;
  localparam int SQRT_STEPS  = 32;
  localparam int SQRT_CNT_W  = 5;
  localparam logic [ACC_W-1:0] SQRT_TOP_BIT = 64'h4000_0000_0000_0000;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_STRIDE  = 1'b0,
    REG_COMPLEX = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_DONE = 3'b100
  } sqrt_state_e;

  typedef struct packed {
    logic signed [FIELD_W-1:0] re;
    logic signed [FIELD_W-1:0] im;
    logic                      last;
  } in_t;

  typedef struct packed {
    logic [NORM_W-1:0] norm;
    logic              saturated;
  } out_t;

  typedef struct packed {
    logic [STRIDE_W-1:0] stride;
    logic                complex_mode;
  } cfg_t;

endpackage

FILE: rtl/enr_stream_if.sv
// ----------------------------------------------------------------------------
// Stream interface
// Valid/ready channel carrying one payload of a configurable type.
// ----------------------------------------------------------------------------
interface enr_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

FILE: rtl/enr_front.sv
// ----------------------------------------------------------------------------
// Front end
// Selects strided elements and forms their squared magnitudes in two stages.
// ----------------------------------------------------------------------------
module enr_front #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  enr_pkg::cfg_t cfg_i,
  enr_stream_if.sink    in,
  enr_stream_if.source  out
);
  import enr_pkg::*;

  localparam int SQ_W = 2 * SAMPLE_BITS;

  function automatic logic [SAMPLE_BITS-1:0] magnitude(input logic [FIELD_W-1:0] raw);
    logic [31:0]            wide;
    logic [SAMPLE_BITS-1:0] s;
    wide = {{(32 - FIELD_W){1'b0}}, raw};
    s    = wide[SAMPLE_BITS-1:0];
    return s[SAMPLE_BITS-1] ? (~s + 1'b1) : s;
  endfunction

  logic [STRIDE_W-1:0]    pos_q, pos_d, pos_inc, eff_stride;
  logic                   va_q, vb_q;
  logic [SAMPLE_BITS-1:0] mag_re_q, mag_im_q, mag_re_d, mag_im_d;
  logic                   last_a_q, last_b_q;
  logic [SQ_W-1:0]        sq_re_q, sq_im_q;
  logic                   in_acc, adv_a, adv_b, sel;

  assign adv_b    = vb_q && out.ready;
  assign adv_a    = va_q && (!vb_q || adv_b);
  assign in.ready = !va_q || adv_a;
  assign in_acc   = in.valid && in.ready;

  always_comb begin
    eff_stride = (cfg_i.stride == '0) ? STRIDE_W'(1) : cfg_i.stride;
    pos_inc    = pos_q + 1'b1;
    sel        = (pos_q == '0);
    if (in.data.last || (pos_inc >= eff_stride)) begin
      pos_d = '0;
    end else begin
      pos_d = pos_inc;
    end
    mag_re_d = sel ? magnitude(in.data.re) : '0;
    mag_im_d = (sel && cfg_i.complex_mode) ? magnitude(in.data.im) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      va_q  <= 1'b0;
      vb_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        pos_q <= pos_d;
      end
      if (in.ready) begin
        va_q <= in.valid;
      end
      if (!vb_q || adv_b) begin
        vb_q <= adv_a;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      mag_re_q <= mag_re_d;
      mag_im_q <= mag_im_d;
      last_a_q <= in.data.last;
    end
    if (adv_a) begin
      sq_re_q  <= SQ_W'(mag_re_q) * SQ_W'(mag_re_q);
      sq_im_q  <= SQ_W'(mag_im_q) * SQ_W'(mag_im_q);
      last_b_q <= last_a_q;
    end
  end

  assign out.valid     = vb_q;
  assign out.data.term = sq_re_q + sq_im_q;
  assign out.data.last = last_b_q;

endmodule

FILE: rtl/enr_fifo.sv
// ----------------------------------------------------------------------------
// Term queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module enr_fifo #(
  parameter type T = logic
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  enr_stream_if.sink   in,
  enr_stream_if.source out
);
  import enr_pkg::*;

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  T                 mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign in.ready  = (cnt_q != CNT_W'(FIFO_DEPTH));
  assign out.valid = (cnt_q != '0);
  assign out.data  = mem_q[rd_q];
  assign push      = in.valid && in.ready;
  assign pop       = out.valid && out.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in.data;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(FIFO_DEPTH))
    else $error("Queue count exceeds its depth.");

  a_empty_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == '0 |-> wr_q == rd_q)
    else $error("Empty queue with unequal pointers.");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && !pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("Queue count did not follow a lone push.");

endmodule

FILE: rtl/enr_back.sv
// ----------------------------------------------------------------------------
// Back end
// Saturating accumulator and iterative integer square root with output register.
// ----------------------------------------------------------------------------
module enr_back (
  input  logic         clk_i,
  input  logic         rst_ni,
  enr_stream_if.sink   in,
  enr_stream_if.source out
);
  import enr_pkg::*;

  sqrt_state_e           state_q, state_d;
  logic [ACC_W-1:0]      sum_q, sum_d, sum_new;
  logic                  sat_q, sat_d, sat_new;
  logic [ACC_W:0]        acc_sum;
  logic [ACC_W-1:0]      rem_q, rem_d, res_q, res_d, bit_q, bit_d, trial;
  logic [SQRT_CNT_W-1:0] cnt_q, cnt_d;
  logic                  flag_q, flag_d;
  logic                  out_valid_q, out_valid_d;
  out_t                  out_q, out_d;
  logic                  pop;

  assign in.ready  = !in.data.last || (state_q == S_IDLE);
  assign pop       = in.valid && in.ready;
  assign out.valid = out_valid_q;
  assign out.data  = out_q;

  always_comb begin
    acc_sum     = {1'b0, sum_q} + (ACC_W + 1)'(in.data.term);
    sum_new     = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
    sat_new     = sat_q | acc_sum[ACC_W];
    trial       = res_q + bit_q;
    state_d     = state_q;
    sum_d       = sum_q;
    sat_d       = sat_q;
    rem_d       = rem_q;
    res_d       = res_q;
    bit_d       = bit_q;
    cnt_d       = cnt_q;
    flag_d      = flag_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    if (out.valid && out.ready) begin
      out_valid_d = 1'b0;
    end

    if (pop) begin
      if (in.data.last) begin
        sum_d = '0;
        sat_d = 1'b0;
      end else begin
        sum_d = sum_new;
        sat_d = sat_new;
      end
    end

    unique case (state_q)
      S_IDLE: begin
        if (pop && in.data.last) begin
          state_d = S_RUN;
          rem_d   = sum_new;
          res_d   = '0;
          bit_d   = SQRT_TOP_BIT;
          cnt_d   = '0;
          flag_d  = sat_new;
        end
      end
      S_RUN: begin
        if (rem_q >= trial) begin
          rem_d = rem_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out.ready) begin
          out_d.norm      = res_q[NORM_W-1:0];
          out_d.saturated = flag_q;
          out_valid_d     = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      sat_q       <= sat_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    flag_q <= flag_d;
    out_q  <= out_d;
  end

  a_sat_pinned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sat_q |-> sum_q == '1)
    else $error("Saturation flag set while the sum is below its maximum.");

  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in.valid && in.ready && in.data.last |-> state_q == S_IDLE)
    else $error("Vector end taken while the square root unit is busy.");

  a_sqrt_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN && cnt_q == SQRT_CNT_W'(SQRT_STEPS - 1) |=> state_q == S_DONE)
    else $error("Square root did not finish after its last step.");

endmodule

FILE: rtl/euclidean_norm_stream.sv
// ----------------------------------------------------------------------------
// Euclidean norm stream
// Streaming floor integer square root of the sum of squared magnitudes.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake        Payload
//  in_i      sink       valid/ready      re, im, last
//  out_o     source     valid/ready      norm, saturated
//  cfg       write      cfg_we_i         cfg_idx_i, cfg_wdata_i
//
//  One element transaction is accepted per cycle while the queue has room.
//  Each vector end starts an iterative square root, one result bit per cycle;
//  it overlaps the accumulation of the next vector, and a further vector end
//  waits until it has finished. Reset is asynchronous and needs no
//  clearing pass.
// ----------------------------------------------------------------------------
module euclidean_norm_stream #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  enr_stream_if.sink                      in_i,
  enr_stream_if.source                    out_o,
  input  logic                            cfg_we_i,
  input  logic [enr_pkg::REG_IDX_W-1:0]   cfg_idx_i,
  input  logic [enr_pkg::STRIDE_W-1:0]    cfg_wdata_i
);
  import enr_pkg::*;

  typedef struct packed {
    logic [2*SAMPLE_BITS-1:0] term;
    logic                     last;
  } term_t;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stride       <= STRIDE_W'(1);
      cfg_q.complex_mode <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_STRIDE:  cfg_q.stride       <= cfg_wdata_i;
        REG_COMPLEX: cfg_q.complex_mode <= cfg_wdata_i[0];
        default:     cfg_q              <= cfg_q;
      endcase
    end
  end

  enr_stream_if #(.T(term_t)) front_q ();
  enr_stream_if #(.T(term_t)) q_back ();

  enr_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_q),
    .in    (in_i),
    .out   (front_q)
  );

  enr_fifo #(
    .T(term_t)
  ) u_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in    (front_q),
    .out   (q_back)
  );

  enr_back u_back (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in    (q_back),
    .out   (out_o)
  );

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Euclidean norm stream testbench
// Streams real and complex vectors through the block under a range of stride
// and mode settings, with random idling on both channels and one long output
// hold-off. A scoreboard predicts each norm and saturation flag from every
// accepted element transaction and checks each output transaction in order.
// ----------------------------------------------------------------------------
module tb;

  import enr_pkg::*;

  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 50;
  localparam int DRAIN_LIMIT  = 5000;
  localparam int PHASE_ITEMS  = 40;

  class norm_tracker;
    logic [STRIDE_W-1:0] stride;
    logic                complex_mode;
    logic [ACC_W-1:0]    sum_sq;
    logic [STRIDE_W-1:0] pos;
    logic                sat_seen;
    out_t                pending[$];
    int unsigned         mismatches;
    int unsigned         elements;
    int unsigned         vectors;

    function new();
      stride       = 1;
      complex_mode = 1'b0;
      sum_sq       = '0;
      pos          = '0;
      sat_seen     = 1'b0;
      mismatches   = 0;
      elements     = 0;
      vectors      = 0;
    endfunction

    function automatic logic [ACC_W-1:0] square_of(logic signed [FIELD_W-1:0] v);
      longint m;
      m = v;
      if (m < 0) m = -m;
      return ACC_W'(m * m);
    endfunction

    function automatic logic [NORM_W-1:0] floor_root(logic [ACC_W-1:0] x);
      logic [NORM_W-1:0] r;
      logic [NORM_W-1:0] c;
      r = '0;
      for (int b = NORM_W - 1; b >= 0; b--) begin
        c = r | (NORM_W'(1) << b);
        if ({32'b0, c} * {32'b0, c} <= x) r = c;
      end
      return r;
    endfunction

    function void absorb_element(in_t el);
      logic [ACC_W:0]      total;
      logic [ACC_W-1:0]    term;
      logic [STRIDE_W-1:0] step;
      out_t                res;
      step = (stride == 0) ? STRIDE_W'(1) : stride;
      elements++;
      if (pos == 0) begin
        term = square_of(el.re);
        if (complex_mode) term = term + square_of(el.im);
        total = {1'b0, sum_sq} + {1'b0, term};
        if (total[ACC_W]) begin
          sum_sq   = '1;
          sat_seen = 1'b1;
        end else begin
          sum_sq = total[ACC_W-1:0];
        end
      end
      pos = pos + 1'b1;
      if (pos >= step) pos = '0;
      if (el.last) begin
        res.norm      = floor_root(sum_sq);
        res.saturated = sat_seen;
        pending.push_back(res);
        sum_sq   = '0;
        pos      = '0;
        sat_seen = 1'b0;
      end
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_norm(out_t got);
      out_t want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result: norm %0d saturated %0d",
                         got.norm, got.saturated));
        return;
      end
      want = pending.pop_front();
      vectors++;
      if (got.norm !== want.norm)
        report($sformatf("vector %0d: norm expected %0d, got %0d",
                         vectors, want.norm, got.norm));
      if (got.saturated !== want.saturated)
        report($sformatf("vector %0d: saturated expected %0d, got %0d",
                         vectors, want.saturated, got.saturated));
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [REG_IDX_W-1:0] cfg_idx_i;
  logic [STRIDE_W-1:0] cfg_wdata_i;

  enr_stream_if #(.T(in_t))  in_if ();
  enr_stream_if #(.T(out_t)) out_if ();

  euclidean_norm_stream i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_if),
    .out_o       (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  norm_tracker tracker = new();
  bit          steady;
  bit          hold_off_req;
  bit          offering;
  int unsigned settings;
  int unsigned sent;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("tb: FAIL");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) tracker.absorb_element(in_if.data);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) tracker.check_norm(out_if.data);
  end

  initial begin
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
        out_if.ready <= 1'b1;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic in_t element(logic signed [FIELD_W-1:0] re,
                                  logic signed [FIELD_W-1:0] im, logic last);
    in_t el;
    el.re   = re;
    el.im   = im;
    el.last = last;
    return el;
  endfunction

  function automatic logic signed [FIELD_W-1:0] random_sample();
    case ($urandom_range(0, 7))
      0:       return {1'b1, {(FIELD_W-1){1'b0}}};
      1:       return {1'b0, {(FIELD_W-1){1'b1}}};
      2:       return '0;
      3:       return '1;
      default: return FIELD_W'($urandom());
    endcase
  endfunction

  task automatic push_element(input in_t el);
    in_if.valid <= 1'b1;
    in_if.data  <= el;
    offering = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    sent++;
    if (!steady && $urandom_range(0, 7) == 0) begin
      in_if.valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
  endtask

  task automatic push_vector(input int len, input bit closed);
    for (int k = 0; k < len; k++)
      push_element(element(random_sample(), random_sample(), closed && k == len - 1));
  endtask

  task automatic finish_phase();
    int waited;
    if (offering) begin
      in_if.valid <= 1'b0;
      offering = 1'b0;
    end
    waited = 0;
    while (tracker.pending.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [STRIDE_W-1:0] s, input logic c);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_STRIDE;
    cfg_wdata_i <= s;
    @(posedge clk_i);
    tracker.stride = s;
    cfg_idx_i   <= REG_COMPLEX;
    cfg_wdata_i <= STRIDE_W'(c);
    @(posedge clk_i);
    tracker.complex_mode = c;
    cfg_we_i <= 1'b0;
    settings++;
  endtask

  initial begin
    logic [STRIDE_W-1:0] strides [8] = '{2, 7, 2, 255, 1, 128, 3, 1};
    bit                  modes   [8] = '{0, 1, 1, 1, 0, 0, 1, 1};
    logic signed [FIELD_W-1:0] lo;
    logic signed [FIELD_W-1:0] hi;
    int                  goal;
    int unsigned         leftover;

    lo = {1'b1, {(FIELD_W-1){1'b0}}};
    hi = {1'b0, {(FIELD_W-1){1'b1}}};
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = REG_STRIDE;
    cfg_wdata_i  = '0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    steady       = 1'b0;
    hold_off_req = 1'b0;
    offering     = 1'b0;
    settings     = 0;
    sent         = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: stride one, real mode, imaginary part ignored.
    push_element(element(hi, 0, 1'b1));
    push_element(element(lo, hi, 1'b1));
    push_element(element(0, lo, 1'b1));
    push_element(element(3, lo, 1'b0));
    push_element(element(-4, hi, 1'b1));
    push_element(element(-1, 5, 1'b1));
    finish_phase();

    write_config(1, 1'b1);
    push_element(element(lo, lo, 1'b1));
    push_element(element(hi, hi, 1'b1));
    push_element(element(3, 4, 1'b0));
    push_element(element(0, -5, 1'b1));
    push_element(element(-1, -1, 1'b1));
    finish_phase();

    // The last element falls on an unselected position here.
    write_config(3, 1'b1);
    push_vector(5, 1'b1);
    finish_phase();

    write_config(0, 1'b0);
    push_vector(4, 1'b1);
    finish_phase();

    for (int p = 0; p < 8; p++) begin
      write_config(strides[p], modes[p]);
      if (p == 7) steady = 1'b1;
      goal = sent + PHASE_ITEMS;
      if (p == 0) begin
        hold_off_req = 1'b1;
        for (int k = 0; k < 16; k++) push_vector(1, 1'b1);
      end
      while (sent < goal)
        push_vector(($urandom_range(0, 3) == 0) ? $urandom_range(9, 40)
                                                 : $urandom_range(1, 8), 1'b1);
      // Odd phases leave a vector open so that the next stride lands mid-vector.
      if (p % 2 == 1) push_vector($urandom_range(3, 6), 1'b0);
      finish_phase();
    end

    leftover = tracker.pending.size();
    if (leftover != 0)
      tracker.report($sformatf("%0d expected results never arrived", leftover));
    $display("Covered %0d element transactions in %0d vectors over %0d register settings,",
             tracker.elements, tracker.vectors, settings);
    $display("including stride zero, a mid-vector stride change and a long output hold-off.");
    if (tracker.mismatches == 0) begin
      $display("tb: PASS");
    end else begin
      $display("%0d mismatches in total", tracker.mismatches);
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
